// File: design/skt_pkg.sv
// shared types and codes for the sorted key table
`default_nettype none
package skt_pkg;
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_MISSING  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam int REC_W = 64 + 64 + 18 + 31;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] project_code;
    logic [17:0] hours;
    logic [30:0] salary;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  position;
    logic [63:0] found_project;
    logic [17:0] found_hours;
    logic [30:0] found_salary;
    logic [9:0]  entry_total;
  } rsp_t;

  // stored record, key first
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] project_code;
    logic [17:0] hours;
    logic [30:0] salary;
  } rec_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_PROBE, OP_STEP, OP_WRITE_NEW, OP_COPY, OP_FETCH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic rd_en;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic hit;
    logic full;
    logic shift_done;
    logic empty;
  } dp_sts_t;
endpackage
`default_nettype wire

// File: design/skt_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/skt_datapath.sv
// search bounds, shift pointer, record memory and result register
`default_nettype none
module skt_datapath #(
  parameter int ENTRIES = 512
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire skt_pkg::dp_cmd_t dcmd,
  input  wire skt_pkg::req_t    req,
  input  wire logic             req_take,
  output skt_pkg::dp_sts_t      sts,
  output skt_pkg::rsp_t         rsp_data
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  skt_pkg::req_t    cur;
  logic [CW-1:0]    count;
  logic [CW-1:0]    lo, hi, ptr;
  logic [CW-1:0]    mid;
  logic [AW-1:0]    raddr, waddr;
  logic             we;
  skt_pkg::rec_t    rd, wdata;
  logic             hit;
  logic [8:0]       res_pos;
  logic [63:0]      res_proj;
  logic [17:0]      res_hrs;
  logic [30:0]      res_sal;

  assign mid = lo + ((hi - lo) >> 1);

  skt_ram #(.WIDTH(skt_pkg::REC_W), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  // read address per operation
  always_comb begin
    raddr = mid[AW-1:0];
    if (dcmd.op == skt_pkg::OP_COPY || dcmd.op == skt_pkg::OP_FETCH) begin
      if (cur.cmd == skt_pkg::CMD_INSERT) raddr = AW'(ptr - CW'(1));
      else raddr = AW'(ptr + CW'(1));
    end else if (dcmd.op == skt_pkg::OP_STEP) begin
      raddr = lo[AW-1:0];
    end
  end

  // writes: shift copy, new record or update
  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = rd;
    if (dcmd.op == skt_pkg::OP_COPY) begin
      we = 1'b1;
    end else if (dcmd.op == skt_pkg::OP_WRITE_NEW) begin
      we    = 1'b1;
      waddr = lo[AW-1:0];
      wdata = '{key: cur.key, project_code: cur.project_code,
                hours: cur.hours, salary: cur.salary};
    end
  end

  assign sts.search_done = (lo >= hi);
  assign sts.hit         = hit;
  assign sts.full        = (count == CW'(ENTRIES));
  assign sts.empty       = 1'b0;
  assign sts.shift_done  = (cur.cmd == skt_pkg::CMD_INSERT) ? (ptr <= lo)
                                                            : (ptr + CW'(1) >= count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (req_take) begin
        cur <= req;
        lo  <= '0;
        hi  <= count;
        hit <= 1'b0;
        if (req.cmd == skt_pkg::CMD_CLEAR) count <= '0;
      end
      unique case (dcmd.op)
        skt_pkg::OP_PROBE: begin
          // result of read at mid arrives next cycle in OP_STEP
        end
        skt_pkg::OP_STEP: begin
          if (lo < hi) begin
            if (rd.key < cur.key) lo <= mid + CW'(1);
            else hi <= mid;
          end
        end
        skt_pkg::OP_LOAD: begin
          // rd now holds record at lo (issued by last step), check hit
          hit      <= (lo < count) && (rd.key == cur.key);
          res_proj <= rd.project_code;
          res_hrs  <= rd.hours;
          res_sal  <= rd.salary;
          res_pos  <= 9'(lo);
          ptr <= (cur.cmd == skt_pkg::CMD_INSERT) ? count : lo;
        end
        skt_pkg::OP_COPY: begin
          if (cur.cmd == skt_pkg::CMD_INSERT) ptr <= ptr - CW'(1);
          else ptr <= ptr + CW'(1);
        end
        skt_pkg::OP_WRITE_NEW: begin
          res_proj <= cur.project_code;
          res_hrs  <= cur.hours;
          res_sal  <= cur.salary;
          res_pos  <= 9'(lo);
          if (!hit) count <= count + CW'(1);
        end
        default: ;
      endcase
      if (dcmd.rd_en) count <= count - CW'(1);
    end
  end

  // status field is filled by the top level from the controller
  assign rsp_data = '{status: 3'd0, position: res_pos, found_project: res_proj,
                      found_hours: res_hrs, found_salary: res_sal,
                      entry_total: 10'(count)};
endmodule
`default_nettype wire

// File: design/skt_ctrl.sv
// sequencer for search, shift and result hand-off
`default_nettype none
module skt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire logic [1:0]       cmd,
  input  wire skt_pkg::dp_sts_t sts,
  input  wire logic             out_fire,
  output skt_pkg::dp_cmd_t      dcmd,
  output logic                  busy,
  output logic                  out_pend,
  output logic [2:0]            status,
  output logic                  zero_data
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_WNEW  = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_SETTL = 4'd7;
  localparam logic [3:0] S_COPY  = 4'd8;

  logic [3:0] state, state_next;
  logic [1:0] op;
  logic [2:0] status_next;
  logic       zero_next, pend_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    dcmd        = '{op: skt_pkg::OP_NONE, rd_en: 1'b0};
    status_next = status;
    zero_next   = zero_data;
    pend_next   = out_pend;
    if (out_fire) pend_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == skt_pkg::CMD_CLEAR) begin
            status_next = skt_pkg::ST_DELETED;
            zero_next   = 1'b1;
            pend_next   = 1'b1;
          end else begin
            state_next = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        dcmd.op = skt_pkg::OP_PROBE;
        state_next = sts.search_done ? S_RD : S_SETTL;
      end
      S_SETTL: begin
        dcmd.op = skt_pkg::OP_STEP;
        state_next = S_SRCH;
      end
      S_RD: begin
        // read at lo
        dcmd.op = skt_pkg::OP_STEP;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        dcmd.op = skt_pkg::OP_LOAD;
        state_next = S_DONE;
      end
      S_DONE: begin
        zero_next = 1'b0;
        if (op == skt_pkg::CMD_LOOKUP) begin
          status_next = sts.hit ? skt_pkg::ST_FOUND : skt_pkg::ST_MISSING;
          zero_next   = !sts.hit;
          pend_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (op == skt_pkg::CMD_DELETE) begin
          if (!sts.hit) begin
            status_next = skt_pkg::ST_MISSING;
            zero_next   = 1'b1;
            pend_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            status_next = skt_pkg::ST_DELETED;
            state_next  = S_SHIFT;
          end
        end else if (sts.hit) begin
          status_next = skt_pkg::ST_UPDATED;
          state_next  = S_WNEW;
        end else if (sts.full) begin
          status_next = skt_pkg::ST_FULL;
          zero_next   = 1'b1;
          pend_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          status_next = skt_pkg::ST_INSERTED;
          state_next  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          if (op == skt_pkg::CMD_DELETE) begin
            dcmd.rd_en = 1'b1;
            pend_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_WNEW;
          end
        end else begin
          // read the neighbor record; it is written one slot over next cycle
          dcmd.op    = skt_pkg::OP_FETCH;
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        dcmd.op    = skt_pkg::OP_COPY;
        state_next = S_SHIFT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (state == S_WNEW) begin
      dcmd.op    = skt_pkg::OP_WRITE_NEW;
      pend_next  = 1'b1;
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_pend <= 1'b0;
    end else begin
      state    <= state_next;
      out_pend <= pend_next;
    end
    if (in_fire) op <= cmd;
    status    <= status_next;
    zero_data <= zero_next;
  end
endmodule
`default_nettype wire

// File: design/sorted_key_table_core.sv
// top level of the sorted key table
//
// a table of up to ENTRIES records kept in ascending key order in one ram.
// input channel in / in_valid / in_ready carries a command transaction:
// lookup, insert or update, delete, clear. output channel out / out_valid /
// out_ready returns exactly one result transaction per command.
// a command is taken only when the block is idle and no result is waiting.
// clear needs no search; lookup runs p binary search probes
// (p up to log2(count+1) rounded up), each probe being one ram read and
// one bound update, then reads the record at the found slot; update writes
// it, delete moves the records above it down, and insert moves them up
// before writing the new record, with one ram read and write per move.
// the next command is taken the cycle after the result leaves.
// reset empties the table at once (count cleared; no clearing pass).
// a stalled receiver holds the result, and no new command is taken.
`default_nettype none
module sorted_key_table_core #(
  parameter int ENTRIES = 512
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire skt_pkg::req_t in,
  input  wire logic          in_valid,
  output logic               in_ready,
  output skt_pkg::rsp_t      out,
  output logic               out_valid,
  input  wire logic          out_ready
);
  skt_pkg::dp_cmd_t dcmd;
  skt_pkg::dp_sts_t sts;
  skt_pkg::rsp_t    dp_rsp;
  logic             busy, pend, zero_data, in_fire, out_fire;
  logic [2:0]       status;

  assign in_ready  = !busy && !pend;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = pend;
  assign out_fire  = out_valid && out_ready;

  skt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .dcmd(dcmd), .req(in), .req_take(in_fire),
    .sts(sts), .rsp_data(dp_rsp)
  );

  skt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .cmd(in.cmd), .sts(sts),
    .out_fire(out_fire), .dcmd(dcmd), .busy(busy), .out_pend(pend),
    .status(status), .zero_data(zero_data)
  );

  // misses, full and clear report zero data
  always_comb begin
    out             = dp_rsp;
    out.status      = status;
    if (zero_data) begin
      out.position      = '0;
      out.found_project = '0;
      out.found_hours   = '0;
      out.found_salary  = '0;
    end
  end

`ifndef ASSERT_OFF
  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    pend |-> !in_ready) else $error("command taken while result pending");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy || pend) else $error("command dropped");
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out.entry_total <= 10'(ENTRIES)) else $error("count overflow");
`endif
endmodule
`default_nettype wire

// File: sim/testbench.sv
// testbench for sorted_key_table_core: random and directed table commands checked against a behavioral table
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 512;

  // behavioral copy of the sorted table; only entries below count are ever read
  class table_scoreboard;
    skt_pkg::rec_t   recs[ENTRIES];
    int              count;
    skt_pkg::rsp_t   pending[$];
    int              errors;
    int              checked;

    function void clear_all();
      count = 0;
    endfunction

    // lower-bound binary search over the valid entries
    function int lower_bound(logic [63:0] k, output bit hit);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (recs[mid].key < k) lo = mid + 1;
        else hi = mid;
      end
      hit = (lo < count) && (recs[lo].key == k);
      return lo;
    endfunction

    function void note_command(skt_pkg::req_t r);
      skt_pkg::rsp_t res;
      bit   hit;
      int   p;
      res = '0;
      if (r.cmd == skt_pkg::CMD_CLEAR) begin
        count = 0;
        res.status = skt_pkg::ST_DELETED;
      end else begin
        p = lower_bound(r.key, hit);
        case (r.cmd)
          skt_pkg::CMD_LOOKUP: begin
            if (hit) begin
              res.status = skt_pkg::ST_FOUND;
              res.position = p[8:0];
              res.found_project = recs[p].project_code;
              res.found_hours = recs[p].hours;
              res.found_salary = recs[p].salary;
            end else res.status = skt_pkg::ST_MISSING;
          end
          skt_pkg::CMD_INSERT: begin
            if (hit) begin
              recs[p] = '{r.key, r.project_code, r.hours, r.salary};
              res.status = skt_pkg::ST_UPDATED;
            end else if (count >= ENTRIES) begin
              res.status = skt_pkg::ST_FULL;
            end else begin
              for (int i = count; i > p; i--) recs[i] = recs[i-1];
              recs[p] = '{r.key, r.project_code, r.hours, r.salary};
              count++;
              res.status = skt_pkg::ST_INSERTED;
            end
            if (res.status != skt_pkg::ST_FULL) begin
              res.position = p[8:0];
              res.found_project = r.project_code;
              res.found_hours = r.hours;
              res.found_salary = r.salary;
            end
          end
          default: begin
            if (hit) begin
              res.status = skt_pkg::ST_DELETED;
              res.position = p[8:0];
              res.found_project = recs[p].project_code;
              res.found_hours = recs[p].hours;
              res.found_salary = recs[p].salary;
              for (int i = p; i + 1 < count; i++) recs[i] = recs[i+1];
              count--;
            end else res.status = skt_pkg::ST_MISSING;
          end
        endcase
      end
      res.entry_total = count[9:0];
      pending.push_back(res);
    endfunction

    function void check_result(skt_pkg::rsp_t got);
      skt_pkg::rsp_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic           clk;
  logic           rst;
  skt_pkg::req_t  in;
  logic           in_valid;
  logic           in_ready;
  skt_pkg::rsp_t  out;
  logic           out_valid;
  logic           out_ready;

  table_scoreboard sb;
  int    sent;
  bit    hold_on;       // asks the receiver for its long hold-off
  int    held = 0;      // hold-off cycles, counted by the receiver process
  bit    stall_free;    // stretch with no idling on either side

  // keys a table the test can reach: a small pool so hits are frequent
  logic [63:0] key_pool[64];

  sorted_key_table_core #(.ENTRIES(ENTRIES)) u_dut (
    .clk(clk), .rst(rst), .in(in), .in_valid(in_valid), .in_ready(in_ready),
    .out(out), .out_valid(out_valid), .out_ready(out_ready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // push one command transaction, waiting for the handshake
  task automatic send_cmd(skt_pkg::req_t r);
    if (!stall_free) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_command(r);
    sent++;
    @(negedge clk);
  endtask

  function automatic skt_pkg::req_t make_cmd(logic [1:0] c, logic [63:0] k);
    skt_pkg::req_t r;
    r.cmd = c;
    r.key = k;
    r.project_code = {$urandom, $urandom};
    r.hours = 18'($urandom);
    r.salary = 31'($urandom);
    return r;
  endfunction

  // stop offering and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off when requested
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_on && held < 300) begin
      held <= held + 1;
      out_ready <= 1'b0;
    end else out_ready <= stall_free || ($urandom_range(99) >= 11);
  end

  // sample results at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out);
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    skt_pkg::req_t r;
    int   n;
    sb = new();
    sb.clear_all();
    sb.errors = 0;
    sb.checked = 0;
    sent = 0;
    hold_on = 0;
    stall_free = 0;
    rst = 1'b1;
    in = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    for (int i = 0; i < 64; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h4144_4100_0000_0000;   // "ADA"
    key_pool[3] = 64'h7E7E_7E7E_7E7E_7E7E;   // all '~'
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty-table misses, extreme keys and payloads, update, delete, clear
    send_cmd(make_cmd(skt_pkg::CMD_LOOKUP, key_pool[2]));
    send_cmd(make_cmd(skt_pkg::CMD_DELETE, key_pool[2]));
    r = '{skt_pkg::CMD_INSERT, 64'h0, 64'h0, 18'h0, 31'h0};
    send_cmd(r);
    r = '{skt_pkg::CMD_INSERT, '1, '1, '1, '1};
    send_cmd(r);
    send_cmd(make_cmd(skt_pkg::CMD_INSERT, key_pool[3]));
    send_cmd(make_cmd(skt_pkg::CMD_INSERT, key_pool[2]));
    send_cmd(make_cmd(skt_pkg::CMD_INSERT, key_pool[2]));     // update in place
    send_cmd(make_cmd(skt_pkg::CMD_LOOKUP, '1));
    send_cmd(make_cmd(skt_pkg::CMD_LOOKUP, 64'h0));
    send_cmd(make_cmd(skt_pkg::CMD_LOOKUP, 64'h1));            // miss between entries
    send_cmd(make_cmd(skt_pkg::CMD_DELETE, 64'h0));            // delete at the head
    send_cmd(make_cmd(skt_pkg::CMD_DELETE, '1));               // delete at the tail
    send_cmd(make_cmd(skt_pkg::CMD_DELETE, 64'h5));            // delete miss
    send_cmd(make_cmd(skt_pkg::CMD_CLEAR, key_pool[4]));
    send_cmd(make_cmd(skt_pkg::CMD_LOOKUP, key_pool[2]));      // gone after clear
    drain();

    // fill the table to capacity with ascending keys, then hit the full case
    stall_free = 1;
    for (int i = 0; i < ENTRIES; i++)
      send_cmd(make_cmd(skt_pkg::CMD_INSERT, 64'h1000 + 64'(i) * 16));
    send_cmd(make_cmd(skt_pkg::CMD_INSERT, 64'h5));             // full
    send_cmd(make_cmd(skt_pkg::CMD_INSERT, 64'h1000));          // update while full
    send_cmd(make_cmd(skt_pkg::CMD_LOOKUP, 64'h1000 + 511 * 16));
    send_cmd(make_cmd(skt_pkg::CMD_DELETE, 64'h1000 + 7 * 16)); // long shift down
    send_cmd(make_cmd(skt_pkg::CMD_INSERT, 64'h3));             // long shift up to full
    send_cmd(make_cmd(skt_pkg::CMD_CLEAR, 64'h0));
    stall_free = 0;

    // long receiver hold-off while commands keep coming
    hold_on = 1;
    for (int i = 0; i < 6; i++)
      send_cmd(make_cmd(skt_pkg::CMD_INSERT, key_pool[$urandom_range(63)]));
    drain();   // sender pause until everything is back

    // random part: mostly inserts and lookups on a small key pool
    for (int i = 0; i < 70; i++) begin
      stall_free = (i >= 30 && i < 50);
      n = $urandom_range(99);
      if (n < 40) r = make_cmd(skt_pkg::CMD_INSERT, key_pool[$urandom_range(63)]);
      else if (n < 70) r = make_cmd(skt_pkg::CMD_LOOKUP, key_pool[$urandom_range(63)]);
      else if (n < 95) r = make_cmd(skt_pkg::CMD_DELETE, key_pool[$urandom_range(63)]);
      else if (n < 98) r = make_cmd(skt_pkg::CMD_LOOKUP, {$urandom, $urandom});
      else r = make_cmd(skt_pkg::CMD_CLEAR, {$urandom, $urandom});
      send_cmd(r);
    end
    stall_free = 0;
    drain();
    repeat (1200) @(negedge clk);

    $display("covered %0d commands: empty and full table, head and tail edits, updates,",
             sent);
    $display("clears, misses and a long result stall; %0d results compared, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sorted_key_table_core.f
design/skt_pkg.sv
design/skt_ram.sv
design/skt_datapath.sv
design/skt_ctrl.sv
design/sorted_key_table_core.sv
sim/testbench.sv
